[src/utc_pkg.sv]
package utc_pkg;

    typedef enum logic [1:0] {
        MODE_U8_DEC  = 2'd0,
        MODE_U8_ENC  = 2'd1,
        MODE_U16_DEC = 2'd2,
        MODE_U16_ENC = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CP   = 3'd2,
        ST_NO_LOW   = 3'd3,
        ST_LONE_LOW = 3'd4,
        ST_ENC_FAIL = 3'd5
    } status_t;

    localparam logic [20:0] REPL_CP  = 21'h00FFFD;
    localparam logic [20:0] MAX_CP   = 21'h10FFFF;
    localparam logic [20:0] PLANE1   = 21'h010000;
    localparam logic [5:0]  HI_TAG   = 6'b110110;
    localparam logic [5:0]  LO_TAG   = 6'b110111;
    localparam logic [1:0]  CONT_TAG = 2'b10;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  len;
        logic        lead_err;
        logic [25:0] sum;
        logic [31:0] cp;
        logic        cp_big;
        logic        cp_wide;
        logic        cp_surr;
        logic [2:0]  enc_len;
        logic [15:0] first_unit;
        logic [15:0] second_unit;
        logic        hi_first;
        logic        lo_first;
        logic        lo_second;
    } utc_s1_t;

    typedef struct packed {
        mode_t       mode;
        status_t     status;
        logic [2:0]  count;
        logic [20:0] cp;
    } utc_s2_t;

    function automatic logic [25:0] marker_offset(input logic [2:0] len);
        logic [25:0] off;
        case (len)
            3'd2:    off = 26'h0003080;
            3'd3:    off = 26'h00E2080;
            3'd4:    off = 26'h3C82080;
            default: off = 26'h0000000;
        endcase
        return off;
    endfunction

endpackage

[src/utc_classify.sv]
module utc_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [1:0]        mode,
    input  logic [7:0]        octet0,
    input  logic [7:0]        octet1,
    input  logic [7:0]        octet2,
    input  logic [7:0]        octet3,
    input  logic [2:0]        octets_available,
    input  logic [15:0]       first_unit,
    input  logic [15:0]       second_unit,
    input  logic [31:0]       code_point_in,
    output logic              dn_valid,
    input  logic              dn_ready,
    output utc_pkg::utc_s1_t  dn_data
);

    logic             valid_reg;
    utc_pkg::utc_s1_t data_reg;
    utc_pkg::utc_s1_t data_next;
    logic [2:0]       len;

    always_comb
    begin
        if (octet0[7] == 1'b0)
            len = 3'd1;
        else if (octet0[7:5] == 3'b110)
            len = 3'd2;
        else if (octet0[7:4] == 4'b1110)
            len = 3'd3;
        else if (octet0[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
    end

    always_comb
    begin
        data_next = '0;
        data_next.mode     = utc_pkg::mode_t'(mode);
        data_next.len      = len;
        data_next.lead_err = (len == 3'd0) || (len > octets_available);
        case (len)
            3'd1:    data_next.sum = 26'(octet0);
            3'd2:    data_next.sum = 26'({octet0, 6'b0}) + 26'(octet1);
            3'd3:    data_next.sum = 26'({octet0, 12'b0}) + 26'({octet1, 6'b0})
                                   + 26'(octet2);
            3'd4:    data_next.sum = {octet0, 18'b0} + 26'({octet1, 12'b0})
                                   + 26'({octet2, 6'b0}) + 26'(octet3);
            default: data_next.sum = '0;
        endcase
        data_next.cp      = code_point_in;
        data_next.cp_big  = (|code_point_in[31:21]) || (code_point_in[20:0] > utc_pkg::MAX_CP);
        data_next.cp_wide = |code_point_in[31:16];
        data_next.cp_surr = !data_next.cp_wide && (code_point_in[15:11] == 5'b11011);
        if (code_point_in < 32'h80)
            data_next.enc_len = 3'd1;
        else if (code_point_in < 32'h800)
            data_next.enc_len = 3'd2;
        else if (!data_next.cp_wide)
            data_next.enc_len = 3'd3;
        else if (!data_next.cp_big)
            data_next.enc_len = 3'd4;
        else
            data_next.enc_len = 3'd0;
        data_next.first_unit  = first_unit;
        data_next.second_unit = second_unit;
        data_next.hi_first    = first_unit[15:10] == utc_pkg::HI_TAG;
        data_next.lo_first    = first_unit[15:10] == utc_pkg::LO_TAG;
        data_next.lo_second   = second_unit[15:10] == utc_pkg::LO_TAG;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[src/utc_resolve.sv]
module utc_resolve (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              replace_on_error,
    input  logic              up_valid,
    output logic              up_ready,
    input  utc_pkg::utc_s1_t  up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output utc_pkg::utc_s2_t  dn_data
);

    logic             valid_reg;
    utc_pkg::utc_s2_t data_reg;
    utc_pkg::utc_s2_t data_next;
    logic [26:0]      diff;
    logic [20:0]      sub;

    assign diff = {1'b0, up_data.sum} - {1'b0, utc_pkg::marker_offset(up_data.len)};
    assign sub  = up_data.cp[20:0] - utc_pkg::PLANE1;

    always_comb
    begin
        data_next        = '0;
        data_next.mode   = up_data.mode;
        data_next.status = utc_pkg::ST_OK;
        case (up_data.mode)
            utc_pkg::MODE_U8_DEC:
            begin
                if (up_data.lead_err)
                begin
                    data_next.status = utc_pkg::ST_BAD_LEAD;
                    data_next.cp     = utc_pkg::REPL_CP;
                end
                else if (diff[26] || (diff[25:0] > 26'(utc_pkg::MAX_CP)))
                begin
                    data_next.status = utc_pkg::ST_BAD_CP;
                    data_next.cp     = utc_pkg::REPL_CP;
                end
                else
                begin
                    data_next.cp    = diff[20:0];
                    data_next.count = up_data.len;
                end
            end
            utc_pkg::MODE_U8_ENC:
            begin
                if (up_data.enc_len != 3'd0)
                begin
                    data_next.cp    = up_data.cp[20:0];
                    data_next.count = up_data.enc_len;
                end
                else if (replace_on_error)
                begin
                    data_next.cp    = utc_pkg::REPL_CP;
                    data_next.count = 3'd3;
                end
                else
                    data_next.status = utc_pkg::ST_ENC_FAIL;
            end
            utc_pkg::MODE_U16_DEC:
            begin
                if (up_data.hi_first && up_data.lo_second)
                begin
                    data_next.cp    = {1'b0, up_data.first_unit[9:0], up_data.second_unit[9:0]}
                                    + utc_pkg::PLANE1;
                    data_next.count = 3'd2;
                end
                else if (up_data.hi_first)
                begin
                    data_next.status = utc_pkg::ST_NO_LOW;
                    data_next.cp     = utc_pkg::REPL_CP;
                end
                else if (up_data.lo_first)
                begin
                    data_next.status = utc_pkg::ST_LONE_LOW;
                    data_next.cp     = utc_pkg::REPL_CP;
                end
                else
                begin
                    data_next.cp    = {5'b0, up_data.first_unit};
                    data_next.count = 3'd1;
                end
            end
            default:
            begin
                if (up_data.cp_big || up_data.cp_surr)
                begin
                    data_next.status = utc_pkg::ST_BAD_CP;
                    data_next.cp     = utc_pkg::REPL_CP;
                end
                else if (up_data.cp_wide)
                begin
                    data_next.cp    = sub;
                    data_next.count = 3'd2;
                end
                else
                begin
                    data_next.cp    = up_data.cp[20:0];
                    data_next.count = 3'd1;
                end
            end
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[src/utc_format.sv]
module utc_format (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  utc_pkg::utc_s2_t  up_data,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [20:0]       code_point_out,
    output logic [7:0]        byte_out0,
    output logic [7:0]        byte_out1,
    output logic [7:0]        byte_out2,
    output logic [7:0]        byte_out3,
    output logic [15:0]       unit_out0,
    output logic [15:0]       unit_out1,
    output logic [2:0]        unit_count,
    output logic [2:0]        status
);

    logic        valid_reg;
    logic [20:0] cp_reg,    cp_next;
    logic [7:0]  b0_reg,    b0_next;
    logic [7:0]  b1_reg,    b1_next;
    logic [7:0]  b2_reg,    b2_next;
    logic [7:0]  b3_reg,    b3_next;
    logic [15:0] u0_reg,    u0_next;
    logic [15:0] u1_reg,    u1_next;
    logic [2:0]  count_reg, count_next;
    logic [2:0]  status_reg, status_next;
    logic [20:0] c;

    assign c = up_data.cp;

    always_comb
    begin
        cp_next     = '0;
        b0_next     = '0;
        b1_next     = '0;
        b2_next     = '0;
        b3_next     = '0;
        u0_next     = '0;
        u1_next     = '0;
        count_next  = up_data.count;
        status_next = 3'(up_data.status);
        case (up_data.mode)
            utc_pkg::MODE_U8_DEC, utc_pkg::MODE_U16_DEC:
                cp_next = c;
            utc_pkg::MODE_U8_ENC:
            begin
                case (up_data.count)
                    3'd1:
                        b0_next = c[7:0];
                    3'd2:
                    begin
                        b0_next = {3'b110, c[10:6]};
                        b1_next = {utc_pkg::CONT_TAG, c[5:0]};
                    end
                    3'd3:
                    begin
                        b0_next = {4'b1110, c[15:12]};
                        b1_next = {utc_pkg::CONT_TAG, c[11:6]};
                        b2_next = {utc_pkg::CONT_TAG, c[5:0]};
                    end
                    3'd4:
                    begin
                        b0_next = {5'b11110, c[20:18]};
                        b1_next = {utc_pkg::CONT_TAG, c[17:12]};
                        b2_next = {utc_pkg::CONT_TAG, c[11:6]};
                        b3_next = {utc_pkg::CONT_TAG, c[5:0]};
                    end
                    default:
                        b0_next = '0;
                endcase
            end
            default:
            begin
                if (up_data.status != utc_pkg::ST_OK)
                    u0_next = c[15:0];
                else if (up_data.count == 3'd2)
                begin
                    u0_next = {utc_pkg::HI_TAG, c[19:10]};
                    u1_next = {utc_pkg::LO_TAG, c[9:0]};
                end
                else
                    u0_next = c[15:0];
            end
        endcase
    end

    assign up_ready = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            cp_reg     <= cp_next;
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            b2_reg     <= b2_next;
            b3_reg     <= b3_next;
            u0_reg     <= u0_next;
            u1_reg     <= u1_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign result_valid   = valid_reg;
    assign code_point_out = cp_reg;
    assign byte_out0      = b0_reg;
    assign byte_out1      = b1_reg;
    assign byte_out2      = b2_reg;
    assign byte_out3      = b3_reg;
    assign unit_out0      = u0_reg;
    assign unit_out1      = u1_reg;
    assign unit_count     = count_reg;
    assign status         = status_reg;

endmodule

[src/unicode_transcode_unit.sv]
// Pipeline: an accepted item beat is registered in the classify, resolve and
// format stages, in that order, before it leaves as its result beat.
// Throughput: one item per cycle; each stage holds under stall and refills as
// soon as its successor drains.
// Reset: rst_n clears all stage valid bits and sets replace_on_error to 1.
module unicode_transcode_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  octet0,
    input  logic [7:0]  octet1,
    input  logic [7:0]  octet2,
    input  logic [7:0]  octet3,
    input  logic [2:0]  octets_available,
    input  logic [15:0] first_unit,
    input  logic [15:0] second_unit,
    input  logic [31:0] code_point_in,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_point_out,
    output logic [7:0]  byte_out0,
    output logic [7:0]  byte_out1,
    output logic [7:0]  byte_out2,
    output logic [7:0]  byte_out3,
    output logic [15:0] unit_out0,
    output logic [15:0] unit_out1,
    output logic [2:0]  unit_count,
    output logic [2:0]  status
);

    logic             replace_reg;
    logic             s1_ready;
    logic             s1_valid;
    utc_pkg::utc_s1_t s1_data;
    logic             s2_ready;
    logic             s2_valid;
    utc_pkg::utc_s2_t s2_data;
    logic             s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replace_reg <= 1'b1;
        else if (cfg_write_en)
            replace_reg <= cfg_write_data;
    end

    assign item_stall = !s1_ready;

    utc_classify u_classify (
        .clk              (clk),
        .rst_n            (rst_n),
        .up_valid         (item_valid),
        .up_ready         (s1_ready),
        .mode             (mode),
        .octet0           (octet0),
        .octet1           (octet1),
        .octet2           (octet2),
        .octet3           (octet3),
        .octets_available (octets_available),
        .first_unit       (first_unit),
        .second_unit      (second_unit),
        .code_point_in    (code_point_in),
        .dn_valid         (s1_valid),
        .dn_ready         (s2_ready),
        .dn_data          (s1_data)
    );

    utc_resolve u_resolve (
        .clk              (clk),
        .rst_n            (rst_n),
        .replace_on_error (replace_reg),
        .up_valid         (s1_valid),
        .up_ready         (s2_ready),
        .up_data          (s1_data),
        .dn_valid         (s2_valid),
        .dn_ready         (s3_ready),
        .dn_data          (s2_data)
    );

    utc_format u_format (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (s2_valid),
        .up_ready       (s3_ready),
        .up_data        (s2_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .code_point_out (code_point_out),
        .byte_out0      (byte_out0),
        .byte_out1      (byte_out1),
        .byte_out2      (byte_out2),
        .byte_out3      (byte_out3),
        .unit_out0      (unit_out0),
        .unit_out1      (unit_out1),
        .unit_count     (unit_count),
        .status         (status)
    );

    a_ok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == 3'(utc_pkg::ST_OK)) |-> unit_count != 3'd0)
        else $error("ok result with zero count");

    a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != 3'(utc_pkg::ST_OK)) |-> unit_count == 3'd0)
        else $error("error result with nonzero count");

    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> code_point_out <= utc_pkg::MAX_CP)
        else $error("code point out of range");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s2_ready |=> s1_valid && $stable(s1_data))
        else $error("classify stage dropped a stalled beat");

endmodule
